[src/pcpa_pkg.sv]
// Shared constants, types and helper functions of the per-CPU page allocator.
package pcpa_pkg;

  localparam int CPU_COUNT = 8;
  localparam int PAGE_COUNT = 32768;
  localparam int PAGE_BYTES = 4096;

  localparam int CPU_W = (CPU_COUNT > 1) ? $clog2(CPU_COUNT) : 1;
  localparam int IDX_W = (PAGE_COUNT > 1) ? $clog2(PAGE_COUNT) : 1;
  localparam int OFF_W = $clog2(PAGE_BYTES);
  localparam int COUNT_W = 16;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE = 1'b1;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_OOM = 2'd1;
  localparam logic [1:0] ST_BAD = 2'd2;

  localparam logic CFG_REGION_START = 1'b0;
  localparam logic CFG_REGION_END = 1'b1;

  localparam logic [31:0] REGION_START_RESET = 32'h8000_0000;
  localparam logic [31:0] REGION_END_RESET = 32'h8800_0000;

  typedef struct packed {
    logic found;
    logic [CPU_W-1:0] cpu;
  } pick_t;

  function automatic logic [CPU_W-1:0] cpu_mod(input logic [2:0] value);
    logic [3:0] rem;
    rem = {1'b0, value};
    for (int i = 0; i < 8; i++) begin
      if (rem >= 4'(CPU_COUNT)) begin
        rem = rem - 4'(CPU_COUNT);
      end
    end
    return CPU_W'(rem);
  endfunction

endpackage

[src/pcpa_link_ram.sv]
// Single-port-write, registered-read memory that holds the free-list links.
module pcpa_link_ram #(
  parameter int DEPTH = 32768,
  parameter int WIDTH = 15
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[src/pcpa_pick.sv]
// Round-robin pick of the first non-empty free list starting at the requesting CPU.
module pcpa_pick (
  input  logic [pcpa_pkg::CPU_COUNT-1:0] nonempty,
  input  logic [pcpa_pkg::CPU_W-1:0]     start,
  output pcpa_pkg::pick_t                pick
);

  logic [pcpa_pkg::CPU_W:0]   sum;
  logic [pcpa_pkg::CPU_W-1:0] cand;

  always_comb begin
    pick = '0;
    sum = '0;
    cand = '0;
    for (int k = pcpa_pkg::CPU_COUNT - 1; k >= 0; k--) begin
      sum = {1'b0, start} + (pcpa_pkg::CPU_W + 1)'(k);
      if (sum >= (pcpa_pkg::CPU_W + 1)'(pcpa_pkg::CPU_COUNT)) begin
        sum = sum - (pcpa_pkg::CPU_W + 1)'(pcpa_pkg::CPU_COUNT);
      end
      cand = pcpa_pkg::CPU_W'(sum);
      if (nonempty[cand]) begin
        pick.found = 1'b1;
        pick.cpu = cand;
      end
    end
  end

endmodule

[src/per_cpu_page_allocator_with_steal.sv]
// Top level of the per-CPU page allocator: request control, list heads, counts and result register.
// A request passes through S_IDLE and then S_DONE: in the cycle it is accepted the block checks a
// free, picks the list for an allocate and starts the read of the link memory; in S_DONE, once the
// output is free, the read data becomes the new list head and the result is loaded. Because the
// link memory read is registered and the head update follows it, no new request is taken until
// the result is loaded; a result that is not taken holds the block in S_DONE. The lists start empty
// after reset and are filled by frees.
module per_cpu_page_allocator_with_steal (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        operation,
  input  logic [2:0]  cpu,
  input  logic [31:0] address,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] page_address,
  output logic [1:0]  status,
  output logic [2:0]  source_cpu
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_DONE = 1'b1;

  logic state;
  logic [31:0] region_start;
  logic [31:0] region_end;
  logic [pcpa_pkg::IDX_W-1:0] list_head [pcpa_pkg::CPU_COUNT];
  logic [pcpa_pkg::COUNT_W-1:0] free_count [pcpa_pkg::CPU_COUNT];

  logic pend_pop;
  logic [1:0] pend_status;
  logic [pcpa_pkg::CPU_W-1:0] pend_cpu;
  logic [pcpa_pkg::IDX_W-1:0] pend_idx;

  logic in_accept;
  logic [pcpa_pkg::CPU_W-1:0] req_cpu;
  logic [pcpa_pkg::CPU_COUNT-1:0] nonempty;
  pcpa_pkg::pick_t pick;
  logic [32:0] base;
  logic [32:0] diff;
  logic free_ok;
  logic [pcpa_pkg::IDX_W-1:0] free_idx;
  logic do_push;
  logic do_pop;
  logic [pcpa_pkg::IDX_W-1:0] link_data;
  logic out_free;

  assign in_stall = rst || (state != S_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign req_cpu = pcpa_pkg::cpu_mod(cpu);
  assign out_free = !out_valid || !out_stall;

  always_comb begin
    for (int i = 0; i < pcpa_pkg::CPU_COUNT; i++) begin
      nonempty[i] = (free_count[i] != '0);
    end
  end

  pcpa_pick u_pick (
    .nonempty (nonempty),
    .start    (req_cpu),
    .pick     (pick)
  );

  assign base = ({1'b0, region_start} + 33'(pcpa_pkg::PAGE_BYTES - 1))
                & ~33'(pcpa_pkg::PAGE_BYTES - 1);
  assign diff = {1'b0, address} - base;
  assign free_ok = (address[pcpa_pkg::OFF_W-1:0] == '0) && (address >= region_start)
                   && (address < region_end) && ({1'b0, address} >= base)
                   && ((diff >> pcpa_pkg::OFF_W) < 33'(pcpa_pkg::PAGE_COUNT));
  assign free_idx = pcpa_pkg::IDX_W'(diff >> pcpa_pkg::OFF_W);

  assign do_push = in_accept && (operation == pcpa_pkg::OP_FREE) && free_ok;
  assign do_pop = in_accept && (operation == pcpa_pkg::OP_ALLOC) && pick.found;

  pcpa_link_ram #(
    .DEPTH (pcpa_pkg::PAGE_COUNT),
    .WIDTH (pcpa_pkg::IDX_W)
  ) u_link_ram (
    .clk     (clk),
    .wr_en   (do_push),
    .wr_addr (free_idx),
    .wr_data (list_head[req_cpu]),
    .rd_en   (do_pop),
    .rd_addr (list_head[pick.cpu]),
    .rd_data (link_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      region_start <= pcpa_pkg::REGION_START_RESET;
      region_end <= pcpa_pkg::REGION_END_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        pcpa_pkg::CFG_REGION_START: region_start <= cfg_data;
        pcpa_pkg::CFG_REGION_END: region_end <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < pcpa_pkg::CPU_COUNT; i++) begin
        free_count[i] <= '0;
      end
    end else if (do_push) begin
      free_count[req_cpu] <= free_count[req_cpu] + pcpa_pkg::COUNT_W'(1);
    end else if (do_pop) begin
      free_count[pick.cpu] <= free_count[pick.cpu] - pcpa_pkg::COUNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      list_head[req_cpu] <= free_idx;
    end else if (state == S_DONE && out_free && pend_pop) begin
      list_head[pend_cpu] <= link_data;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      pend_pop <= do_pop;
      pend_idx <= list_head[pick.cpu];
      if (operation == pcpa_pkg::OP_FREE) begin
        pend_status <= free_ok ? pcpa_pkg::ST_OK : pcpa_pkg::ST_BAD;
        pend_cpu <= free_ok ? req_cpu : '0;
      end else begin
        pend_status <= pick.found ? pcpa_pkg::ST_OK : pcpa_pkg::ST_OOM;
        pend_cpu <= pick.found ? pick.cpu : '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_accept) begin
            state <= S_DONE;
          end
          if (out_valid && !out_stall) begin
            out_valid <= 1'b0;
          end
        end
        S_DONE: begin
          if (out_free) begin
            state <= S_IDLE;
            out_valid <= 1'b1;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && out_free) begin
      page_address <= pend_pop
                      ? 32'(base + (33'(pend_idx) << pcpa_pkg::OFF_W)) : 32'd0;
      status <= pend_status;
      source_cpu <= 3'(pend_cpu);
    end
  end

  a_accept_enters_done: assert property (@(posedge clk) disable iff (rst)
    in_accept |=> (state == S_DONE) && in_stall)
    else $error("Accepted request did not move the block to its second cycle.");

  a_done_loads_result: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE) && out_free |=> out_valid && (state == S_IDLE))
    else $error("Second cycle finished without presenting a result.");

  a_oom_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == pcpa_pkg::ST_OOM) |-> (page_address == '0) && (source_cpu == '0))
    else $error("Out-of-memory result carries a page or a CPU.");

  a_bad_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == pcpa_pkg::ST_BAD) |-> (page_address == '0) && (source_cpu == '0))
    else $error("Bad-address result carries a page or a CPU.");

endmodule

[tb/testbench.sv]
// Self-checking testbench for the per-CPU page allocator: directed and random requests against a behavioral model.
module testbench;
  import pcpa_pkg::*;

  localparam longint CYCLE_LIMIT = 1000000;
  localparam int unsigned HOLD_OFF = 120;
  localparam int unsigned MAX_REPORTS = 200;

  typedef struct packed {
    logic [31:0] page_address;
    logic [1:0]  status;
    logic [2:0]  source_cpu;
  } reply_t;

  typedef enum int unsigned {
    NOISE_RANDOM,
    NOISE_UNALIGNED,
    NOISE_ABOVE_END,
    NOISE_BELOW_BASE,
    NOISE_PAST_LIMIT
  } noise_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_write = 1'b0;
  logic        cfg_index = CFG_REGION_START;
  logic [31:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        operation = OP_ALLOC;
  logic [2:0]  cpu = '0;
  logic [31:0] address = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] page_address;
  logic [1:0]  status;
  logic [2:0]  source_cpu;

  logic [31:0]        region_lo;
  logic [31:0]        region_hi;
  logic [IDX_W-1:0]   link_of [PAGE_COUNT];
  logic [IDX_W-1:0]   top_of [CPU_COUNT];
  logic [COUNT_W-1:0] count_of [CPU_COUNT];
  bit                 page_held [PAGE_COUNT];
  reply_t             pending_replies [$];

  bit          idle_on = 1'b1;
  int unsigned hold_cycles = 0;
  int unsigned fail_count = 0;
  int unsigned request_count = 0;
  int unsigned reply_count = 0;
  int unsigned ok_count = 0;
  int unsigned oom_count = 0;
  int unsigned bad_count = 0;
  int unsigned steal_count = 0;
  longint      cycle_count = 0;

  per_cpu_page_allocator_with_steal uut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [32:0] page_base();
    logic [32:0] rounded;
    rounded = {1'b0, region_lo} + 33'(PAGE_BYTES - 1);
    return rounded - (rounded % 33'(PAGE_BYTES));
  endfunction

  function automatic bit free_slot(input logic [31:0] addr, output int unsigned idx);
    logic [32:0] base;
    logic [32:0] offset;
    base = page_base();
    idx = 0;
    if (addr % PAGE_BYTES != 0 || addr < region_lo || addr >= region_hi ||
        {1'b0, addr} < base) begin
      return 1'b0;
    end
    offset = ({1'b0, addr} - base) / PAGE_BYTES;
    if (offset >= PAGE_COUNT) begin
      return 1'b0;
    end
    idx = int'(offset);
    return 1'b1;
  endfunction

  function automatic int unsigned usable_pages();
    logic [32:0] base;
    logic [32:0] span;
    base = page_base();
    if (base >= {1'b0, region_hi}) begin
      return 0;
    end
    span = ({1'b0, region_hi} - base + PAGE_BYTES - 1) / PAGE_BYTES;
    return (span > PAGE_COUNT) ? PAGE_COUNT : int'(span);
  endfunction

  function automatic int unsigned pages_on_lists();
    int unsigned total;
    total = 0;
    foreach (count_of[i]) total += count_of[i];
    return total;
  endfunction

  function automatic reply_t allocate_or_free(input logic op, input logic [2:0] req_cpu,
                                              input logic [31:0] addr);
    reply_t r;
    int unsigned c;
    int unsigned t;
    int unsigned idx;
    r = '0;
    r.status = ST_OK;
    c = req_cpu % CPU_COUNT;
    if (op == OP_FREE) begin
      if (!free_slot(addr, idx)) begin
        r.status = ST_BAD;
      end else begin
        link_of[idx] = top_of[c];
        top_of[c] = IDX_W'(idx);
        count_of[c] = count_of[c] + COUNT_W'(1);
        page_held[idx] = 1'b1;
        r.source_cpu = 3'(c);
      end
      return r;
    end
    for (int k = 0; k < CPU_COUNT; k++) begin
      t = (c + k) % CPU_COUNT;
      if (count_of[t] != 0) begin
        idx = top_of[t];
        top_of[t] = link_of[idx];
        count_of[t] = count_of[t] - COUNT_W'(1);
        page_held[idx] = 1'b0;
        r.page_address = 32'(page_base() + 33'(idx) * PAGE_BYTES);
        r.source_cpu = 3'(t);
        if (t != c) begin
          steal_count++;
        end
        return r;
      end
    end
    r.status = ST_OOM;
    return r;
  endfunction

  task automatic reset_model();
    region_lo = REGION_START_RESET;
    region_hi = REGION_END_RESET;
    foreach (link_of[i]) link_of[i] = '0;
    foreach (page_held[i]) page_held[i] = 1'b0;
    foreach (top_of[i]) begin
      top_of[i] = '0;
      count_of[i] = '0;
    end
  endtask

  task automatic send_request(input logic op, input logic [2:0] req_cpu,
                              input logic [31:0] addr);
    reply_t r;
    if (idle_on) begin
      while ($urandom_range(99) < 24) begin
        in_valid <= 1'b0;
        @(negedge clk);
      end
    end
    in_valid <= 1'b1;
    operation <= op;
    cpu <= req_cpu;
    address <= addr;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    r = allocate_or_free(op, req_cpu, addr);
    pending_replies.push_back(r);
    request_count++;
    case (r.status)
      ST_OK: ok_count++;
      ST_OOM: oom_count++;
      default: bad_count++;
    endcase
    @(negedge clk);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (pending_replies.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_region(input logic idx, input logic [31:0] value);
    settle();
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(negedge clk);
    cfg_write <= 1'b0;
    if (idx == CFG_REGION_START) begin
      region_lo = value;
    end else begin
      region_hi = value;
    end
  endtask

  task automatic set_region(input logic [31:0] lo, input logic [31:0] hi);
    write_region(CFG_REGION_START, lo);
    write_region(CFG_REGION_END, hi);
  endtask

  task automatic drain_lists();
    while (pages_on_lists() != 0) send_request(OP_ALLOC, 3'($urandom_range(7)), $urandom());
    foreach (page_held[i]) page_held[i] = 1'b0;
  endtask

  task automatic random_requests(input int unsigned count, input int unsigned free_pct);
    logic [32:0] base;
    logic [31:0] addr;
    logic [2:0]  c;
    int unsigned span;
    int unsigned idx;
    int unsigned pick;
    bit          found;
    noise_t      kind;
    for (int unsigned i = 0; i < count; i++) begin
      base = page_base();
      span = usable_pages();
      c = 3'($urandom_range(7));
      pick = $urandom_range(99);
      addr = $urandom();
      if (pick < free_pct) begin
        found = 1'b0;
        for (int tries = 0; tries < 8 && !found && span != 0; tries++) begin
          idx = $urandom_range(span - 1);
          found = !page_held[idx];
        end
        if (found) begin
          send_request(OP_FREE, c, 32'(base + 33'(idx) * PAGE_BYTES));
        end else begin
          send_request(OP_ALLOC, c, addr);
        end
      end else if (pick < 85) begin
        send_request(OP_ALLOC, c, addr);
      end else begin
        kind = noise_t'($urandom_range(NOISE_PAST_LIMIT));
        case (kind)
          NOISE_UNALIGNED: addr = 32'(base + 33'($urandom_range(span)) * PAGE_BYTES +
                                      33'($urandom_range(PAGE_BYTES - 1, 1)));
          NOISE_ABOVE_END: addr = 32'((({1'b0, region_hi} + PAGE_BYTES - 1) / PAGE_BYTES) *
                                      PAGE_BYTES);
          NOISE_BELOW_BASE: addr = 32'(base - PAGE_BYTES);
          NOISE_PAST_LIMIT: addr = 32'(base + 33'(PAGE_COUNT) * PAGE_BYTES);
          default: ;
        endcase
        // A page already on a list is never freed again here, so no list can run into
        // a link that was never written.
        found = free_slot(addr, idx);
        if (found && page_held[idx]) begin
          send_request(OP_ALLOC, c, addr);
        end else begin
          send_request(OP_FREE, c, addr);
        end
      end
    end
  endtask

  task automatic test_empty_lists();
    send_request(OP_ALLOC, 3'd0, 32'h0000_0000);
    send_request(OP_ALLOC, 3'd7, 32'hFFFF_FFFF);
  endtask

  task automatic test_lifo_order();
    send_request(OP_FREE, 3'd0, 32'h8000_0000);
    send_request(OP_FREE, 3'd0, 32'h87FF_F000);
    send_request(OP_FREE, 3'd7, 32'h8000_1000);
    send_request(OP_ALLOC, 3'd0, 32'h0000_0000);
    send_request(OP_ALLOC, 3'd0, 32'h0000_0000);
    send_request(OP_ALLOC, 3'd7, 32'h0000_0000);
  endtask

  task automatic test_steal_order();
    send_request(OP_FREE, 3'd5, 32'h8000_2000);
    send_request(OP_FREE, 3'd1, 32'h8000_3000);
    send_request(OP_ALLOC, 3'd6, 32'h0000_0000);
    send_request(OP_ALLOC, 3'd6, 32'h0000_0000);
    send_request(OP_ALLOC, 3'd2, 32'h0000_0000);
  endtask

  task automatic test_bad_frees();
    send_request(OP_FREE, 3'd3, 32'h8000_0800);
    send_request(OP_FREE, 3'd3, 32'h7FFF_F000);
    send_request(OP_FREE, 3'd3, 32'h8800_0000);
    send_request(OP_FREE, 3'd3, 32'h0000_0000);
    send_request(OP_FREE, 3'd3, 32'hFFFF_FFFF);
  endtask

  task automatic test_double_free();
    send_request(OP_FREE, 3'd4, 32'h8000_4000);
    send_request(OP_FREE, 3'd4, 32'h8000_4000);
    send_request(OP_ALLOC, 3'd4, 32'h0000_0000);
    send_request(OP_ALLOC, 3'd4, 32'h0000_0000);
    send_request(OP_ALLOC, 3'd4, 32'h0000_0000);
    drain_lists();
  endtask

  task automatic test_region_changes();
    set_region(32'h0000_0801, 32'hFFFF_FFFF);
    send_request(OP_FREE, 3'd2, 32'h0000_0000);
    send_request(OP_FREE, 3'd2, 32'h0000_1000);
    send_request(OP_FREE, 3'd2, 32'h0800_0000);
    send_request(OP_FREE, 3'd2, 32'h0800_1000);
    // Held pages keep their index and come back relative to the new base.
    set_region(32'hFFFF_F000, 32'hFFFF_FFFF);
    send_request(OP_ALLOC, 3'd2, 32'h0000_0000);
    set_region(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_request(OP_FREE, 3'd2, 32'hFFFF_F000);
    send_request(OP_ALLOC, 3'd2, 32'h0000_0000);
    set_region(32'h0000_0000, 32'h0000_0000);
    send_request(OP_FREE, 3'd2, 32'h0000_0000);
    drain_lists();
  endtask

  task automatic test_random_default_region();
    set_region(REGION_START_RESET, REGION_END_RESET);
    hold_cycles = HOLD_OFF;
    random_requests(200, 45);
  endtask

  task automatic test_random_wide_region();
    set_region(32'h0000_0000, 32'hFFFF_FFFF);
    idle_on = 1'b0;
    random_requests(180, 55);
    idle_on = 1'b1;
  endtask

  task automatic test_random_small_regions();
    set_region(32'h1234_5678, 32'h1236_0000);
    random_requests(130, 45);
    set_region(32'hFFFF_8001, 32'hFFFF_FFFF);
    random_requests(100, 45);
  endtask

  task automatic test_random_closed_region();
    set_region(32'hFFFF_FFFF, 32'h0000_0000);
    random_requests(40, 45);
  endtask

  always @(negedge clk) begin
    if (hold_cycles != 0) begin
      out_stall <= 1'b1;
      hold_cycles--;
    end else begin
      out_stall <= idle_on && ($urandom_range(99) < 24);
    end
  end

  always @(posedge clk) begin
    reply_t want;
    if (!rst && out_valid && !out_stall) begin
      reply_count++;
      if (pending_replies.size() == 0) begin
        fail_count++;
        if (fail_count <= MAX_REPORTS) begin
          $error("unexpected result: page_address %h status %0d source_cpu %0d",
                 page_address, status, source_cpu);
        end
      end else begin
        want = pending_replies.pop_front();
        if (page_address !== want.page_address) begin
          fail_count++;
          if (fail_count <= MAX_REPORTS) begin
            $error("page_address: expected %h, actual %h", want.page_address, page_address);
          end
        end
        if (status !== want.status) begin
          fail_count++;
          if (fail_count <= MAX_REPORTS) begin
            $error("status: expected %0d, actual %0d", want.status, status);
          end
        end
        if (source_cpu !== want.source_cpu) begin
          fail_count++;
          if (fail_count <= MAX_REPORTS) begin
            $error("source_cpu: expected %0d, actual %0d", want.source_cpu, source_cpu);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    reset_model();
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_empty_lists();
    test_lifo_order();
    test_steal_order();
    test_bad_frees();
    test_double_free();
    test_region_changes();
    test_random_default_region();
    test_random_wide_region();
    test_random_small_regions();
    test_random_closed_region();
    settle();
    repeat (10) @(posedge clk);
    $display("tb: %0d requests and %0d results checked over several region settings",
             request_count, reply_count);
    $display("tb: %0d granted, %0d out of memory, %0d rejected frees, %0d steals",
             ok_count, oom_count, bad_count, steal_count);
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

[files.f]
src/pcpa_pkg.sv
src/pcpa_link_ram.sv
src/pcpa_pick.sv
src/per_cpu_page_allocator_with_steal.sv
tb/testbench.sv
